FILE: rtl/swrl_pkg.sv
// swrl_pkg: shared types and constants of the sliding window rate limiter.
// Used by every module under rtl/ except swrl_ram; depends on nothing.
package swrl_pkg;

  // Ring depth: most grant stamps the block can remember.
  localparam int MAX_EVENTS = 16;
  localparam int IDX_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

  localparam int STAMP_W    = 32;
  localparam int WAIT_W     = 16;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVENTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 1'd1;

  localparam logic [LIMIT_W-1:0] MAX_EVENTS_RST = 5'd4;
  localparam logic [WAIT_W-1:0]  WINDOW_MS_RST  = 16'd1000;

  // Request codes
  localparam logic OP_TRY     = 1'b0;
  localparam logic OP_RESERVE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [STAMP_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [WAIT_W-1:0] wait_ms;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch request, issue ring read
    logic finish;  // decide, write stamp on grant, load result register
  } cmd_t;

endpackage

FILE: rtl/sliding_window_rate_limiter.sv
// sliding_window_rate_limiter: top level, controller plus datapath.
// Depends on swrl_pkg, swrl_ctrl, swrl_dp (and swrl_ram through swrl_dp).
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  in_data   (op, now_ms)
//   out      from block out_valid / out_stall out_data (granted, wait_ms)
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// Each request has a load step, which reads the ring entry max_events grants
// back from the stamp RAM (registered read), and a decide step that writes back.
// in_stall is high while a request is in its decide state.
// A decision waits while the previous result is still stalled in out_data;
// the next request is taken while a finished result waits.
// Reset (rst, synchronous) clears pointers, fill count, valid flag and sets
// max_events = 4, window_ms = 1000; the ring itself is not cleared, and
// entries are only used once written (fill count gating).
module sliding_window_rate_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  swrl_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output swrl_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data
);

  // load / finish strobes from the sequencer
  swrl_pkg::cmd_t cmd;

  swrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // ring, pointers, limit arithmetic and the result register
  swrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: rtl/swrl_ram.sv
// swrl_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
module swrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/swrl_ctrl.sv
// swrl_ctrl: request sequencer (idle / decide) and output valid flag.
// Depends on swrl_pkg.
module swrl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output swrl_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        // result register must be empty or draining
        if (!out_valid || !out_stall) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_CALC)
    else $error("accepted request did not move to decide state");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished request left no result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC && out_valid && out_stall |=> state == ST_CALC && !$past(cmd.finish))
    else $error("decision finished over an unaccepted result");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.finish))
    else $error("load and finish in one cycle");

endmodule

FILE: rtl/swrl_dp.sv
// swrl_dp: limiter datapath: config registers, ring pointers, stamp ring,
// age / wait arithmetic and result register. Depends on swrl_pkg, swrl_ram.
module swrl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  swrl_pkg::cmd_t                      cmd,
  input  swrl_pkg::req_t                      in_data,
  output swrl_pkg::rsp_t                      out_data,
  input  logic                                cfg_we,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SUM_W = swrl_pkg::CNT_W + 1;

  logic [swrl_pkg::LIMIT_W-1:0] max_events;
  logic [swrl_pkg::WAIT_W-1:0]  window_ms;
  logic [swrl_pkg::IDX_W-1:0]   write_slot;
  logic [swrl_pkg::CNT_W-1:0]   fill_count;
  logic                         req_op;
  logic [swrl_pkg::STAMP_W-1:0] req_now;
  logic                         enough;

  logic [swrl_pkg::CNT_W-1:0]   k;
  logic [SUM_W-1:0]             slot_sum;
  logic [swrl_pkg::IDX_W-1:0]   rd_idx;
  logic [swrl_pkg::STAMP_W-1:0] stamp;
  logic [swrl_pkg::STAMP_W-1:0] age;
  logic [swrl_pkg::STAMP_W-1:0] lead;
  logic [swrl_pkg::STAMP_W:0]   lead_sum;
  logic                         ahead;
  logic                         over;
  logic [swrl_pkg::WAIT_W-1:0]  wait_val;
  logic                         grant;
  logic                         ring_we;
  logic [swrl_pkg::STAMP_W-1:0] store_val;

  // effective limit, clamped into 1..MAX_EVENTS
  always_comb begin
    if (max_events == '0) begin
      k = swrl_pkg::CNT_W'(1);
    end else if (32'(max_events) > 32'(swrl_pkg::MAX_EVENTS)) begin
      k = swrl_pkg::CNT_W'(swrl_pkg::MAX_EVENTS);
    end else begin
      k = swrl_pkg::CNT_W'(max_events);
    end
  end

  // slot k grants back: write_slot - k modulo depth
  always_comb begin
    slot_sum = SUM_W'(write_slot) + SUM_W'(swrl_pkg::MAX_EVENTS) - SUM_W'(k);
    if (slot_sum >= SUM_W'(swrl_pkg::MAX_EVENTS)) begin
      slot_sum = slot_sum - SUM_W'(swrl_pkg::MAX_EVENTS);
    end
    rd_idx = slot_sum[swrl_pkg::IDX_W-1:0];
  end

  // decision on the registered ring read
  always_comb begin
    age      = req_now - stamp;
    lead     = stamp - req_now;
    ahead    = age[swrl_pkg::STAMP_W-1];
    over     = enough && (ahead || age < 32'(window_ms));
    lead_sum = (swrl_pkg::STAMP_W+1)'(window_ms) + (swrl_pkg::STAMP_W+1)'(lead);
    if (!over) begin
      wait_val = '0;
    end else if (ahead) begin
      // future stamp frees window + lead from now, saturated
      wait_val = (|lead_sum[swrl_pkg::STAMP_W:swrl_pkg::WAIT_W]) ? '1
                                                          : lead_sum[swrl_pkg::WAIT_W-1:0];
    end else begin
      wait_val = window_ms - age[swrl_pkg::WAIT_W-1:0];
    end
    grant     = !over || (req_op == swrl_pkg::OP_RESERVE);
    ring_we   = cmd.finish && grant;
    store_val = req_now + swrl_pkg::STAMP_W'(wait_val);
  end

  swrl_ram #(
    .WIDTH (swrl_pkg::STAMP_W),
    .DEPTH (swrl_pkg::MAX_EVENTS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (store_val),
    .re    (cmd.load),
    .raddr (rd_idx),
    .rdata (stamp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_events <= swrl_pkg::MAX_EVENTS_RST;
      window_ms  <= swrl_pkg::WINDOW_MS_RST;
      write_slot <= '0;
      fill_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          swrl_pkg::REG_MAX_EVENTS: max_events <= cfg_data[swrl_pkg::LIMIT_W-1:0];
          swrl_pkg::REG_WINDOW_MS:  window_ms  <= cfg_data[swrl_pkg::WAIT_W-1:0];
          default: ;
        endcase
      end
      if (ring_we) begin
        if (32'(write_slot) == swrl_pkg::MAX_EVENTS - 1) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
        if (fill_count != swrl_pkg::CNT_W'(swrl_pkg::MAX_EVENTS)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= in_data.op;
      req_now <= in_data.now_ms;
      enough  <= (fill_count >= k);
    end
    if (cmd.finish) begin
      out_data.granted <= grant;
      out_data.wait_ms <= wait_val;
    end
  end

endmodule

FILE: tb/sv/rate_limit_check.sv
// rate_limit_check: watches the request, result and register ports of the
// sliding window rate limiter, predicts each grant and compares field by field.
// Depends on swrl_pkg only.
module rate_limit_check
  import swrl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  req_t                  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  rsp_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the grant log and the limits
  logic [STAMP_W-1:0] grant_log [MAX_EVENTS];
  int unsigned        log_head;
  int unsigned        log_fill;
  logic [LIMIT_W-1:0] limit_reg;
  logic [WAIT_W-1:0]  window_reg;
  rsp_t               pending_grants [$];
  int                 errs;

  task automatic log_grant(input logic [STAMP_W-1:0] stamp);
    grant_log[log_head] = stamp;
    log_head = (log_head + 1) % MAX_EVENTS;
    if (log_fill < MAX_EVENTS) log_fill++;
  endtask

  task automatic grant_decision(input req_t r, output rsp_t res);
    int unsigned        lim_eff;
    int unsigned        slot;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] lead;
    logic [33:0]        delay;
    logic               busy;
    logic [WAIT_W-1:0]  hold_ms;
    lim_eff = limit_reg;
    if (lim_eff < 1) lim_eff = 1;
    if (lim_eff > MAX_EVENTS) lim_eff = MAX_EVENTS;
    busy  = 1'b0;
    delay = '0;
    if (log_fill >= lim_eff) begin
      slot = (log_head + MAX_EVENTS - lim_eff) % MAX_EVENTS;
      age  = r.now_ms - grant_log[slot];
      if (age[STAMP_W-1]) begin
        // stamp lies ahead (reserved grant): frees window plus lead from now
        lead  = '0 - age;
        busy  = 1'b1;
        delay = {18'b0, window_reg} + {2'b0, lead};
      end else if (age < {16'b0, window_reg}) begin
        busy  = 1'b1;
        delay = {18'b0, window_reg - age[WAIT_W-1:0]};
      end
    end
    hold_ms = (delay > 34'hFFFF) ? '1 : delay[WAIT_W-1:0];
    if (!busy) begin
      log_grant(r.now_ms);
      res.granted = 1'b1;
      res.wait_ms = '0;
    end else if (r.op == OP_TRY) begin
      res.granted = 1'b0;
      res.wait_ms = hold_ms;
    end else begin
      log_grant(r.now_ms + {16'b0, hold_ms});
      res.granted = 1'b1;
      res.wait_ms = hold_ms;
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    rsp_t pred;
    if (rst) begin
      log_head   = 0;
      log_fill   = 0;
      limit_reg  = MAX_EVENTS_RST;
      window_reg = WINDOW_MS_RST;
      pending_grants.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_EVENTS) limit_reg = cfg_data[LIMIT_W-1:0];
        else if (cfg_index == REG_WINDOW_MS) window_reg = cfg_data[WAIT_W-1:0];
      end
      // results leave only after their request has passed load and decide, so compare first
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got granted=%0d wait_ms=%0d",
                   $time, out_data.granted, out_data.wait_ms);
        end else begin
          want = pending_grants.pop_front();
          if (out_data.granted !== want.granted) begin
            errs++;
            $display("%0t: granted mismatch, expected %0d, got %0d",
                     $time, want.granted, out_data.granted);
          end
          if (out_data.wait_ms !== want.wait_ms) begin
            errs++;
            $display("%0t: wait_ms mismatch, expected %0d, got %0d",
                     $time, want.wait_ms, out_data.wait_ms);
          end
        end
      end
      if (in_valid && !in_stall) begin
        grant_decision(in_data, pred);
        pending_grants = {pending_grants, pred};
      end
    end
    outstanding <= pending_grants.size();
    mismatches  <= errs;
  end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for the sliding window rate limiter.
// Depends on swrl_pkg, the RTL under rtl/ and rate_limit_check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swrl_pkg::*;

  localparam int PHASES     = 9;
  localparam int PER_PHASE  = 156;   // ~1400 random requests overall
  localparam int HOLD_LEN   = 80;    // long receiver hold-off, in cycles
  localparam int SETTLE     = 6;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  req_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rsp_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatches;
  int                    outstanding;

  // Register settings per random phase. Limit words carry junk in the upper
  // bits on one phase; 0 must act as 1 and 31 as the ring depth.
  logic [15:0] limit_plan  [PHASES] = '{16'd4, 16'd1, 16'd16, 16'd31, 16'd0,
                                        16'hFF07, 16'd2, 16'd12, 16'd3};
  logic [15:0] window_plan [PHASES] = '{16'd1000, 16'd1, 16'hFFFF, 16'd500, 16'd200,
                                        16'd3000, 16'd0, 16'd40000, 16'd100};

  logic [31:0] clock_ms;      // request timestamp, only moves forward (mod 2^32)
  int          sent = 0;      // requests accepted so far

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_rate_limiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rate_limit_check i_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Result side. Random stalls, except for a quiet stretch of results and
  // a few long hold-offs that let the block fill up and push back on requests.
  int results_taken = 0;
  int hold_left     = 0;
  int holds_done    = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_taken++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_done < 3 && results_taken >= 250 + 475 * holds_done) begin
        holds_done++;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (results_taken >= 500 && results_taken < 700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 38);
      end
    end
  end

  // Offer one request and hold it until accepted. Random idle cycles go in
  // front, except for a stretch of requests sent back to back.
  task automatic offer(input logic code, input logic [31:0] stamp);
    while (!(sent >= 500 && sent < 700) && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: code, now_ms: stamp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, back to back, only while the block is idle.
  task automatic program_limits(input logic [15:0] limit_word, input logic [15:0] window);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_EVENTS;
    cfg_data  <= limit_word;
    @(posedge clk);
    cfg_index <= REG_WINDOW_MS;
    cfg_data  <= window;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          lim_eff;
    int unsigned base;
    int unsigned step;
    int          pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset limits (4 per 1000 ms): too few stamps, refusal, reserve delay,
    // a stamp exactly one window old, then a chain of reserves that stores
    // grant times ahead of now.
    offer(OP_TRY, 32'd0);
    offer(OP_TRY, 32'd10);
    offer(OP_TRY, 32'd20);
    offer(OP_RESERVE, 32'd30);
    offer(OP_TRY, 32'd40);
    offer(OP_RESERVE, 32'd50);
    offer(OP_TRY, 32'd1000);
    offer(OP_TRY, 32'd1010);
    repeat (4) offer(OP_RESERVE, 32'd1010);

    // One grant per longest window at the top of the time range: reserves get
    // the saturated wait, then time wraps past zero.
    drain();
    program_limits(16'd1, 16'hFFFF);
    repeat (3) offer(OP_RESERVE, 32'hFFFF_FFFF);
    offer(OP_TRY, 32'hFFFF_FFFF);
    offer(OP_TRY, 32'd4);

    // Zero window with a zero limit (acts as 1): a stamp still ahead of now holds these back.
    drain();
    program_limits(16'hFFE0, 16'd0);
    repeat (2) offer(OP_TRY, 32'd100);
    offer(OP_RESERVE, 32'd100);

    // Random phases. Time steps are mostly scaled to window / limit so the
    // limiter sits near its threshold; rare large jumps walk time through
    // the whole 32-bit range and across the wrap.
    clock_ms = 32'd200;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      program_limits(limit_plan[ph], window_plan[ph]);
      lim_eff = limit_plan[ph][LIMIT_W-1:0];
      if (lim_eff < 1) lim_eff = 1;
      if (lim_eff > MAX_EVENTS) lim_eff = MAX_EVENTS;
      base = window_plan[ph] / lim_eff + 1;
      for (int n = 0; n < PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 12) step = 0;
        else if (pick < 70) step = $urandom_range(2 * base);
        else if (pick < 96) step = $urandom_range(window_plan[ph] + 2);
        else if (pick < 98) step = $urandom_range(32'h0010_0000);
        else step = $urandom_range(32'h4000_0000, 32'h2000_0000);
        clock_ms = clock_ms + step;
        offer(logic'($urandom_range(1)), clock_ms);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("** sliding_window_rate_limiter: PASSED **");
    end else begin
      $display("** sliding_window_rate_limiter: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("** sliding_window_rate_limiter: FAILED **");
    $finish;
  end

endmodule

FILE: sliding_window_rate_limiter.f
rtl/swrl_pkg.sv
rtl/swrl_ram.sv
rtl/swrl_ctrl.sv
rtl/swrl_dp.sv
rtl/sliding_window_rate_limiter.sv
tb/sv/rate_limit_check.sv
tb/sv/tb_top.sv
